### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms, clocked on the rising edge and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/hpit_pkg.sv
// ----------------------------------------------------------------------------
// hpit_pkg
// Types, widths and corner tables of the box pair intersection test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpit_pkg;

   localparam int COORD_W  = 24;            // corner coordinate
   localparam int VEC_W    = COORD_W + 1;   // edge vector component
   localparam int AXIS_W   = 2 * VEC_W + 1; // cross product component
   localparam int AL_W     = 26;            // low slice of an axis component
   localparam int AH_W     = AXIS_W - AL_W; // high slice, signed
   localparam int MOP_A_W  = 25;
   localparam int MOP_B_W  = 27;
   localparam int PROD_W   = MOP_A_W + MOP_B_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int DOT_W    = 76;
   localparam int DOTX_W   = SUM_W + AL_W;
   localparam int NUM_MUL  = 6;
   localparam int CNT_W    = 5;

   localparam logic [CNT_W-1:0] BOUND_END = 5'd16;
   localparam logic [CNT_W-1:0] AXRD_END  = 5'd4;
   localparam logic [CNT_W-1:0] PROJ_END  = 5'd19;
   localparam logic [CNT_W-1:0] SWEEP_N   = 5'd16;
   localparam logic [2:0]       FACE_LAST = 3'd5;
   localparam logic [3:0]       EDGE_LAST = 4'd11;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [MOP_A_W-1:0] mop_a_type;
   typedef logic signed [MOP_B_W-1:0] mop_b_type;
   typedef logic signed [PROD_W-1:0]  prod_type;

   typedef struct packed {
      logic      box_select;
      logic [2:0] corner_index;
      coord_type corner_x;
      coord_type corner_y;
      coord_type corner_z;
      logic      last_corner;
   } req_word_type;

   typedef struct packed {
      logic boxes_intersect;
      logic bounds_overlap;
      logic no_usable_axis;
   } rsp_word_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } corner_type;

   typedef struct packed {
      mop_a_type [NUM_MUL-1:0] a;
      mop_b_type [NUM_MUL-1:0] b;
   } mul_ops_type;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_BOUND = 6'b000010,
      S_AXRD  = 6'b000100,
      S_CROSS = 6'b001000,
      S_PROJ  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   // face corners p0, p1, p2
   localparam logic [2:0] FACE_TAB [6][3] = '{
      '{3'd0, 3'd1, 3'd2}, '{3'd4, 3'd5, 3'd6}, '{3'd0, 3'd1, 3'd5},
      '{3'd1, 3'd2, 3'd6}, '{3'd2, 3'd3, 3'd7}, '{3'd3, 3'd0, 3'd4}
   };

   // edge start, end
   localparam logic [2:0] EDGE_TAB [12][2] = '{
      '{3'd0, 3'd1}, '{3'd1, 3'd2}, '{3'd2, 3'd3}, '{3'd3, 3'd0},
      '{3'd4, 3'd5}, '{3'd5, 3'd6}, '{3'd6, 3'd7}, '{3'd7, 3'd4},
      '{3'd0, 3'd4}, '{3'd1, 3'd5}, '{3'd2, 3'd6}, '{3'd3, 3'd7}
   };

endpackage

### hdl/hpit_corner_ram.sv
// ----------------------------------------------------------------------------
// hpit_corner_ram
// Sixteen-entry corner memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpit_corner_ram
   import hpit_pkg::*;
(
   input  logic       clock,
   input  logic       wr_en,
   input  logic [3:0] wr_addr,
   input  corner_type wr_data,
   input  logic       rd_en,
   input  logic [3:0] rd_addr,
   output corner_type rd_data
);

   corner_type mem [16];
   corner_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/hpit_mul_array.sv
// ----------------------------------------------------------------------------
// hpit_mul_array
// Six signed multipliers with registered products, shared by the cross
// product and projection steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpit_mul_array
   import hpit_pkg::*;
(
   input  logic        clock,
   input  mul_ops_type ops,
   output prod_type    prod [NUM_MUL]
);

   prod_type prod_ff [NUM_MUL];

   // multiply and register
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_MUL; i++) begin
         prod_ff[i] <= PROD_W'(ops.a[i]) * PROD_W'(ops.b[i]);
      end
   end

   assign prod = prod_ff;

endmodule

### hdl/hexahedron_pair_intersection_test_core.sv
// ----------------------------------------------------------------------------
// hexahedron_pair_intersection_test_core
// Loads box corners into a corner memory and runs a separating-axis test.
// ----------------------------------------------------------------------------
// Operation: a corner without the last mark is stored and the core stays ready. A last
// corner starts a test: a bounding sweep, then per axis the corner reads, the cross
// product and, for a usable axis, the projection, and finally the result word.
// The single read port of the corner memory reads one corner per cycle in the sweeps.
// Synchronous reset clears the sequencer and result valid; corners need reload.
`timescale 1ns / 1ps

module hexahedron_pair_intersection_test_core
   import hpit_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic face_ph_ff, face_ph_in;
   logic fbox_ff, fbox_in;
   logic [2:0] fidx_ff, fidx_in;
   logic [3:0] ei_ff, ei_in, ej_ff, ej_in;
   logic usable_ff, usable_in, sep_ff, sep_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic rdv_ff, mv_ff, sv_ff;
   logic [3:0] rdi_ff, mi_ff, si_ff;
   logic [1:0] rds_ff;

   corner_type r_ff [4];
   logic signed [AXIS_W-1:0] ax_ff, ay_ff, az_ff;
   logic signed [AXIS_W-1:0] ax_in, ay_in, az_in;
   logic signed [SUM_W-1:0] losum_ff, hisum_ff;
   logic signed [DOT_W-1:0] plo_ff [2];
   logic signed [DOT_W-1:0] phi_ff [2];
   coord_type bmin_ff [2][3];
   coord_type bmax_ff [2][3];

   logic req_acc, rd_en, axis_zero, last_axis, sep_now, bounds_ok;
   logic [3:0] rd_addr;
   logic [3:0] slot_addr [4];
   corner_type rd_data, wr_data;
   logic signed [VEC_W-1:0] ux, uy, uz, vx, vy, vz;
   mul_ops_type ops;
   prod_type prod [NUM_MUL];
   logic signed [DOTX_W-1:0] dot_wide;
   logic signed [DOT_W-1:0] dot;
   coord_type cval [3];

   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign wr_data.x = req_word.corner_x;
   assign wr_data.y = req_word.corner_y;
   assign wr_data.z = req_word.corner_z;

   // corner addresses of the current axis
   always_comb begin
      if (face_ph_ff) begin
         slot_addr[0] = {fbox_ff, FACE_TAB[fidx_ff][0]};
         slot_addr[1] = {fbox_ff, FACE_TAB[fidx_ff][1]};
         slot_addr[2] = {fbox_ff, FACE_TAB[fidx_ff][2]};
         slot_addr[3] = {fbox_ff, FACE_TAB[fidx_ff][2]};
      end else begin
         slot_addr[0] = {1'b0, EDGE_TAB[ei_ff][0]};
         slot_addr[1] = {1'b0, EDGE_TAB[ei_ff][1]};
         slot_addr[2] = {1'b1, EDGE_TAB[ej_ff][0]};
         slot_addr[3] = {1'b1, EDGE_TAB[ej_ff][1]};
      end
   end

   // read port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = cnt_ff[3:0];
      case (state_ff)
         S_BOUND, S_PROJ: rd_en = (cnt_ff < SWEEP_N);
         S_AXRD: begin
            rd_en   = (cnt_ff < AXRD_END);
            rd_addr = slot_addr[cnt_ff[1:0]];
         end
         default: rd_en = 1'b0;
      endcase
   end

   hpit_corner_ram u_ram (
      .clock   (clock),
      .wr_en   (req_acc),
      .wr_addr ({req_word.box_select, req_word.corner_index}),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // edge vectors of the current axis
   assign ux = VEC_W'(r_ff[1].x) - VEC_W'(r_ff[0].x);
   assign uy = VEC_W'(r_ff[1].y) - VEC_W'(r_ff[0].y);
   assign uz = VEC_W'(r_ff[1].z) - VEC_W'(r_ff[0].z);
   assign vx = face_ph_ff ? VEC_W'(r_ff[2].x) - VEC_W'(r_ff[0].x)
                          : VEC_W'(r_ff[3].x) - VEC_W'(r_ff[2].x);
   assign vy = face_ph_ff ? VEC_W'(r_ff[2].y) - VEC_W'(r_ff[0].y)
                          : VEC_W'(r_ff[3].y) - VEC_W'(r_ff[2].y);
   assign vz = face_ph_ff ? VEC_W'(r_ff[2].z) - VEC_W'(r_ff[0].z)
                          : VEC_W'(r_ff[3].z) - VEC_W'(r_ff[2].z);

   // multiplier operands: cross product or projection slices
   always_comb begin
      if (state_ff == S_CROSS) begin
         ops.a[0] = uy; ops.b[0] = MOP_B_W'(vz);
         ops.a[1] = uz; ops.b[1] = MOP_B_W'(vy);
         ops.a[2] = uz; ops.b[2] = MOP_B_W'(vx);
         ops.a[3] = ux; ops.b[3] = MOP_B_W'(vz);
         ops.a[4] = ux; ops.b[4] = MOP_B_W'(vy);
         ops.a[5] = uy; ops.b[5] = MOP_B_W'(vx);
      end else begin
         ops.a[0] = MOP_A_W'(rd_data.x);
         ops.a[1] = MOP_A_W'(rd_data.x);
         ops.a[2] = MOP_A_W'(rd_data.y);
         ops.a[3] = MOP_A_W'(rd_data.y);
         ops.a[4] = MOP_A_W'(rd_data.z);
         ops.a[5] = MOP_A_W'(rd_data.z);
         ops.b[0] = $signed({1'b0, ax_ff[AL_W-1:0]});
         ops.b[1] = MOP_B_W'($signed(ax_ff[AXIS_W-1:AL_W]));
         ops.b[2] = $signed({1'b0, ay_ff[AL_W-1:0]});
         ops.b[3] = MOP_B_W'($signed(ay_ff[AXIS_W-1:AL_W]));
         ops.b[4] = $signed({1'b0, az_ff[AL_W-1:0]});
         ops.b[5] = MOP_B_W'($signed(az_ff[AXIS_W-1:AL_W]));
      end
   end

   hpit_mul_array u_mul (
      .clock (clock),
      .ops   (ops),
      .prod  (prod)
   );

   // axis from cross products
   assign ax_in = AXIS_W'(prod[0] - prod[1]);
   assign ay_in = AXIS_W'(prod[2] - prod[3]);
   assign az_in = AXIS_W'(prod[4] - prod[5]);
   assign axis_zero = (ax_in == '0) && (ay_in == '0) && (az_in == '0);

   // projection from slice sums
   assign dot_wide = (DOTX_W'(hisum_ff) <<< AL_W) + DOTX_W'(losum_ff);
   assign dot      = dot_wide[DOT_W-1:0];
   assign sep_now  = (phi_ff[0] < plo_ff[1]) || (phi_ff[1] < plo_ff[0]);

   assign last_axis = !face_ph_ff && (ei_ff == EDGE_LAST) && (ej_ff == EDGE_LAST);

   // bounding box overlap on all three coordinates
   always_comb begin
      bounds_ok = 1'b1;
      for (int c = 0; c < 3; c++) begin
         if ((bmax_ff[0][c] < bmin_ff[1][c]) || (bmin_ff[0][c] > bmax_ff[1][c])) begin
            bounds_ok = 1'b0;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff + 1'b1;
      face_ph_in   = face_ph_ff;
      fbox_in      = fbox_ff;
      fidx_in      = fidx_ff;
      ei_in        = ei_ff;
      ej_in        = ej_ff;
      usable_in    = usable_ff;
      sep_in       = sep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_acc && req_word.last_corner) begin
               state_in   = S_BOUND;
               face_ph_in = 1'b1;
               fbox_in    = 1'b0;
               fidx_in    = '0;
               ei_in      = '0;
               ej_in      = '0;
               usable_in  = 1'b0;
               sep_in     = 1'b0;
            end
         end
         S_BOUND: begin
            if (cnt_ff == BOUND_END) begin
               state_in = S_AXRD;
               cnt_in   = '0;
            end
         end
         S_AXRD: begin
            if (cnt_ff == AXRD_END) begin
               state_in = S_CROSS;
               cnt_in   = '0;
            end
         end
         S_CROSS, S_PROJ: begin
            if ((state_ff == S_CROSS) && (cnt_ff != '0) && !axis_zero) begin
               usable_in = 1'b1;
               state_in  = S_PROJ;
               cnt_in    = '0;
            end else if (((state_ff == S_CROSS) && (cnt_ff != '0)) ||
                         ((state_ff == S_PROJ) && (cnt_ff == PROJ_END))) begin
               if ((state_ff == S_PROJ) && sep_now) begin
                  sep_in = 1'b1;
               end
               // advance to the next candidate axis
               cnt_in   = '0;
               state_in = last_axis ? S_DONE : S_AXRD;
               if (face_ph_ff) begin
                  if (fidx_ff == FACE_LAST) begin
                     fidx_in = '0;
                     if (fbox_ff) begin
                        face_ph_in = 1'b0;
                     end else begin
                        fbox_in = 1'b1;
                     end
                  end else begin
                     fidx_in = fidx_ff + 1'b1;
                  end
               end else if (ej_ff == EDGE_LAST) begin
                  ej_in = '0;
                  ei_in = ei_ff + 1'b1;
               end else begin
                  ej_in = ej_ff + 1'b1;
               end
            end
         end
         S_DONE: begin
            cnt_in = '0;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_word_in.boxes_intersect = usable_ff && !sep_ff;
               rsp_word_in.bounds_overlap  = bounds_ok;
               rsp_word_in.no_usable_axis  = !usable_ff;
               state_in                    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         face_ph_ff   <= 1'b1;
         fbox_ff      <= 1'b0;
         fidx_ff      <= '0;
         ei_ff        <= '0;
         ej_ff        <= '0;
         usable_ff    <= 1'b0;
         sep_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
         mv_ff        <= 1'b0;
         sv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         face_ph_ff   <= face_ph_in;
         fbox_ff      <= fbox_in;
         fidx_ff      <= fidx_in;
         ei_ff        <= ei_in;
         ej_ff        <= ej_in;
         usable_ff    <= usable_in;
         sep_ff       <= sep_in;
         rsp_valid_ff <= rsp_valid_in;
         rdv_ff       <= rd_en;
         mv_ff        <= rdv_ff && (state_ff == S_PROJ);
         sv_ff        <= mv_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      rdi_ff      <= rd_addr;
      rds_ff      <= cnt_ff[1:0];
      mi_ff       <= rdi_ff;
      si_ff       <= mi_ff;
      losum_ff    <= SUM_W'(prod[0]) + SUM_W'(prod[2]) + SUM_W'(prod[4]);
      hisum_ff    <= SUM_W'(prod[1]) + SUM_W'(prod[3]) + SUM_W'(prod[5]);
      // hold fetched axis corners
      if (rdv_ff && (state_ff == S_AXRD)) begin
         r_ff[rds_ff] <= rd_data;
      end
      // latch the axis
      if ((state_ff == S_CROSS) && (cnt_ff != '0)) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         az_ff <= az_in;
      end
      // track projection interval per box
      if (sv_ff) begin
         if ((si_ff[2:0] == 3'd0) || (dot < plo_ff[si_ff[3]])) begin
            plo_ff[si_ff[3]] <= dot;
         end
         if ((si_ff[2:0] == 3'd0) || (dot > phi_ff[si_ff[3]])) begin
            phi_ff[si_ff[3]] <= dot;
         end
      end
      // track bounding box per box
      if (rdv_ff && (state_ff == S_BOUND)) begin
         for (int c = 0; c < 3; c++) begin
            if ((rdi_ff[2:0] == 3'd0) || (cval[c] < bmin_ff[rdi_ff[3]][c])) begin
               bmin_ff[rdi_ff[3]][c] <= cval[c];
            end
            if ((rdi_ff[2:0] == 3'd0) || (cval[c] > bmax_ff[rdi_ff[3]][c])) begin
               bmax_ff[rdi_ff[3]][c] <= cval[c];
            end
         end
      end
   end

   assign cval[0] = rd_data.x;
   assign cval[1] = rd_data.y;
   assign cval[2] = rd_data.z;

endmodule

### hdl/hpit_checker.sv
// ----------------------------------------------------------------------------
// hpit_checker
// Port-level checks of the intersection test core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hpit_checker
   import hpit_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   // a stalled result word stays offered
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a usable-axis-free test never reports an intersection
   `CHK_SAME(a_rsp_flags, clock, reset, rsp_valid, !(rsp_word.boxes_intersect && rsp_word.no_usable_axis))

   // a last corner starts a test and blocks further loads
   `CHK_NEXT(a_test_busy, clock, reset, req_valid && req_ready && req_word.last_corner, !req_ready)

   // a new result is only issued at the end of a test
   `CHK_SAME(a_rsp_from_test, clock, reset, $rose(rsp_valid), !$past(req_ready))

endmodule

bind hexahedron_pair_intersection_test_core hpit_checker u_hpit_checker (.*);
